### hdl/per_cpu_lockup_watchdog_macros.svh
// assertion macros for the lockup watchdog checker
`ifndef PER_CPU_LOCKUP_WATCHDOG_MACROS_SVH
`define PER_CPU_LOCKUP_WATCHDOG_MACROS_SVH

// checked only while out of reset, sampled on aclk
`define PLWD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("watchdog port check failed");

// checked at every edge, reset included
`define PLWD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("watchdog reset check failed");

`endif

### hdl/plwd_pkg.sv
// shared types and constants of the per-cpu lockup watchdog
`default_nettype none

package plwd_pkg;

    localparam int DEFAULT_NUM_CPUS = 8;

    localparam int CPU_W      = 3;
    localparam int SUM_W      = 32;
    localparam int STALL_W    = 13;
    localparam int TPS_W      = 10;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 10;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    localparam logic [STALL_W-1:0] STALL_MAX = '1;
    // five times the reset tick rate of one
    localparam logic [STALL_W-1:0] THRESHOLD_RESET = 13'd5;

    // item kinds carried in s_tuser
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_TOUCH = 1'b1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TICKS_PER_SECOND = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PANIC_ENABLE     = 1'd1;

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } ctrl_state_t;

    typedef struct packed {
        logic exec;   // item accepted this cycle: update state, load result
    } dp_cmd_t;

endpackage

`default_nettype wire

### hdl/per_cpu_lockup_watchdog.sv
// top level of the per-cpu hard-lockup watchdog
//
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------------
//  s_       | in        | tuser: op; tdata: cpu, irq_sum, veto, zero pad
//  m_       | out       | tdata: lockup, lockup_cpu, halt_request, vetoed, pad
//  cfg_     | in        | write-only: 0 ticks_per_second, 1 panic_enable
//
// one item per cycle unless a held result stalls the input: a per-cpu
// read-modify-write of the register file and the threshold compare complete in the accepting cycle.
// the result is valid in the output register the cycle after acceptance.
// a stalled result blocks input unless it is taken in the same cycle.
// reset clears all counts, sets the threshold to five and panic off.
`default_nettype none

module per_cpu_lockup_watchdog
    import plwd_pkg::*;
#(
    parameter int NUM_CPUS = DEFAULT_NUM_CPUS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic                  s_tuser,   // op
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // cpu, irq_sum, veto, pad
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,   // lockup, lockup_cpu, halt_request, vetoed, pad
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    dp_cmd_t cmd;

    plwd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    plwd_dp #(
        .NUM_CPUS (NUM_CPUS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

### hdl/plwd_ctrl.sv
// handshake controller: tracks the result register and issues datapath commands
`default_nettype none

module plwd_ctrl
    import plwd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output dp_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b1;
        m_tvalid   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_EMPTY: begin
                s_tready = 1'b1;
                cmd.exec = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL: begin
                m_tvalid = 1'b1;
                // result leaving frees the register for a new item in the same cycle
                s_tready = m_tready;
                cmd.exec = s_tvalid && m_tready;
                if (m_tready && !s_tvalid) begin
                    state_next = ST_EMPTY;
                end
            end
            default: begin
                state_next = ST_EMPTY;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/plwd_dp.sv
// datapath: per-cpu count and stall registers, threshold compare, result register
`default_nettype none

module plwd_dp
    import plwd_pkg::*;
#(
    parameter int NUM_CPUS = DEFAULT_NUM_CPUS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               cmd,
    input  wire logic                  s_tuser,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic      [M_TDATA_W-1:0]  m_tdata
);

    // only cpu indexes the 3-bit field can name need storage
    localparam int DEPTH = (NUM_CPUS < (1 << CPU_W)) ? NUM_CPUS : (1 << CPU_W);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CPU_W+5:0] CPU_LIMIT = (CPU_W + 6)'(NUM_CPUS);

    logic [SUM_W-1:0]   last_count_reg  [DEPTH];
    logic [STALL_W-1:0] stall_count_reg [DEPTH];
    logic [STALL_W-1:0] threshold_reg;
    logic [STALL_W-1:0] threshold_next;
    logic               panic_enable_reg;

    logic               lockup_reg;
    logic [CPU_W-1:0]   lockup_cpu_reg;
    logic               halt_request_reg;
    logic               vetoed_reg;

    logic               op;
    logic [CPU_W-1:0]   cpu;
    logic [SUM_W-1:0]   irq_sum;
    logic               veto;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic               tick;
    logic               same;
    logic [STALL_W-1:0] stall_cur;
    logic [STALL_W-1:0] stall_inc;
    logic               hit;
    logic [STALL_W-1:0] stall_new;
    logic               lockup_next;
    logic               vetoed_next;

    assign op      = s_tuser;
    assign cpu     = s_tdata[2:0];
    assign irq_sum = s_tdata[34:3];
    assign veto    = s_tdata[35];
    assign idx     = cpu[IDX_W-1:0];

    assign in_range  = {6'd0, cpu} < CPU_LIMIT;
    assign tick      = (op == OP_TICK) && in_range;
    assign same      = last_count_reg[idx] == irq_sum;
    assign stall_cur = stall_count_reg[idx];
    assign stall_inc = (stall_cur != STALL_MAX) ? stall_cur + 13'd1 : stall_cur;
    // a zero threshold never matches since the advanced count is at least one
    assign hit       = same && (stall_inc == threshold_reg);
    assign stall_new = (same && !(hit && veto)) ? stall_inc : '0;

    assign lockup_next = tick && hit && !veto;
    assign vetoed_next = tick && hit && veto;

    // threshold = 4 * rate + rate
    assign threshold_next = STALL_W'({cfg_wdata, 2'b00}) + STALL_W'(cfg_wdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= THRESHOLD_RESET;
            panic_enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_TICKS_PER_SECOND: threshold_reg    <= threshold_next;
                REG_PANIC_ENABLE:     panic_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                last_count_reg[i]  <= '0;
                stall_count_reg[i] <= '0;
            end
        end else if (cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (op == OP_TOUCH) begin
                    stall_count_reg[i] <= '0;
                end else if (tick && (idx == IDX_W'(i))) begin
                    stall_count_reg[i] <= stall_new;
                    if (!same) begin
                        last_count_reg[i] <= irq_sum;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            lockup_reg       <= lockup_next;
            lockup_cpu_reg   <= cpu;
            halt_request_reg <= lockup_next && panic_enable_reg;
            vetoed_reg       <= vetoed_next;
        end
    end

    assign m_tdata = {2'b00, vetoed_reg, halt_request_reg, lockup_cpu_reg, lockup_reg};

endmodule

`default_nettype wire

### hdl/plwd_checker.sv
// port-level checks of the lockup watchdog, bound to the top level
`default_nettype none

`include "per_cpu_lockup_watchdog_macros.svh"

module plwd_checker
    import plwd_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 s_tuser,
    input wire logic                 m_tvalid,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    logic touch_acc;
    logic res_lockup;
    logic res_halt;
    logic res_vetoed;

    assign touch_acc  = s_tvalid && s_tready && (s_tuser == OP_TOUCH);
    assign res_lockup = m_tdata[0];
    assign res_halt   = m_tdata[4];
    assign res_vetoed = m_tdata[5];

    `PLWD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid)
    `PLWD_ASSERT(a_item_gives_result, (s_tvalid && s_tready) |=> m_tvalid)
    `PLWD_ASSERT(a_touch_quiet, touch_acc |=> !(res_lockup || res_halt || res_vetoed))
    `PLWD_ASSERT(a_halt_needs_lockup, m_tvalid |-> (!res_halt || res_lockup))
    `PLWD_ASSERT(a_lockup_or_veto, m_tvalid |-> !(res_lockup && res_vetoed))

endmodule

bind per_cpu_lockup_watchdog plwd_checker u_plwd_checker (.*);

`default_nettype wire

### sim/plwd_checker.sv
// checker for the lockup watchdog: predicts each result and compares it field by field
`default_nettype none

module plwd_scoreboard
    import plwd_pkg::*;
#(
    parameter int NUM_CPUS = DEFAULT_NUM_CPUS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic                  s_tuser,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                         mismatches,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int THRESHOLD_FACTOR = 5;

    typedef struct packed {
        logic               vetoed;
        logic               halt_request;
        logic [CPU_W-1:0]   cpu;
        logic               lockup;
    } watch_result_t;

    logic [SUM_W-1:0]   last_sum [NUM_CPUS];
    logic [STALL_W-1:0] stall [NUM_CPUS];
    logic [TPS_W-1:0]   tick_rate;
    logic               panic_on;
    watch_result_t      pending_reports [$];
    watch_result_t      expected;
    watch_result_t      seen;

    task automatic flag_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    function automatic watch_result_t advance_watchdog(input logic op,
                                                       input logic [CPU_W-1:0] cpu,
                                                       input logic [SUM_W-1:0] sum,
                                                       input logic veto);
        watch_result_t      res;
        logic [STALL_W-1:0] threshold;
        res = '0;
        res.cpu = cpu;
        threshold = STALL_W'(tick_rate) * STALL_W'(THRESHOLD_FACTOR);
        if (op == OP_TOUCH) begin
            for (int i = 0; i < NUM_CPUS; i++) stall[i] = '0;
        end else if (int'(cpu) < NUM_CPUS) begin
            if (last_sum[cpu] == sum) begin
                if (stall[cpu] != STALL_MAX) stall[cpu] = stall[cpu] + 1'b1;
                if (stall[cpu] == threshold) begin
                    if (veto) begin
                        stall[cpu] = '0;
                        res.vetoed = 1'b1;
                    end else begin
                        res.lockup = 1'b1;
                        res.halt_request = panic_on;
                    end
                end
            end else begin
                last_sum[cpu] = sum;
                stall[cpu] = '0;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CPUS; i++) begin
                last_sum[i] = '0;
                stall[i] = '0;
            end
            tick_rate = TPS_W'(1);
            panic_on = 1'b0;
            mismatches = 0;
            pending_reports.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_TICKS_PER_SECOND: tick_rate = cfg_wdata[TPS_W-1:0];
                    REG_PANIC_ENABLE:     panic_on = cfg_wdata[0];
                    default: ;
                endcase
            end
            // results leave only after their item was accepted, so match them first
            if (m_tvalid && m_tready) begin
                seen = m_tdata[5:0];
                if (pending_reports.size() == 0) begin
                    flag_mismatch("unexpected result", 32'(m_tdata), 0);
                end else begin
                    expected = pending_reports.pop_front();
                    if (seen.lockup != expected.lockup)
                        flag_mismatch("lockup", 32'(seen.lockup), 32'(expected.lockup));
                    if (seen.cpu != expected.cpu)
                        flag_mismatch("lockup_cpu", 32'(seen.cpu), 32'(expected.cpu));
                    if (seen.halt_request != expected.halt_request)
                        flag_mismatch("halt_request", 32'(seen.halt_request),
                                      32'(expected.halt_request));
                    if (seen.vetoed != expected.vetoed)
                        flag_mismatch("vetoed", 32'(seen.vetoed), 32'(expected.vetoed));
                end
            end
            if (s_tvalid && s_tready)
                pending_reports.push_back(advance_watchdog(s_tuser, s_tdata[2:0],
                                                           s_tdata[34:3], s_tdata[35]));
        end
        outstanding = pending_reports.size();
    end

endmodule

`default_nettype wire

### sim/testbench.sv
// stimulus and verdict for the per-cpu lockup watchdog
`default_nettype none

module testbench
    import plwd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 60;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic                  s_tuser;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    mismatches;
    int                    outstanding;

    logic [SUM_W-1:0] sent_sum [DEFAULT_NUM_CPUS];
    bit               no_idle;
    int               hold_requests;
    int               holds_served;
    int               hold_left;
    int               quiet_cycles;

    per_cpu_lockup_watchdog uut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tuser, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_wr_en, .cfg_addr, .cfg_wdata
    );

    plwd_scoreboard u_scoreboard (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tuser, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_wr_en, .cfg_addr, .cfg_wdata,
        .mismatches, .outstanding
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // result side: random back-pressure plus long holds on request
    initial begin
        m_tready = 1'b0;
        holds_served = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_idle || $urandom_range(99) >= 9;
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic send_item(input logic op, input logic [CPU_W-1:0] cpu,
                             input logic [SUM_W-1:0] sum, input logic veto);
        while (!no_idle && $urandom_range(99) < 9) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W-36){1'b0}}, veto, sum, cpu};
        if (op == OP_TICK) sent_sum[cpu] = sum;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering and let every pending result come out
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_watchdog(input logic [TPS_W-1:0] rate, input logic panic);
        write_reg(REG_TICKS_PER_SECOND, CFG_DATA_W'(rate));
        write_reg(REG_PANIC_ENABLE, CFG_DATA_W'(panic));
    endtask

    // mostly stall runs on a hot cpu, with changed counts, touches and vetoes mixed in
    task automatic random_ticks(input int count, input int hold_at, input int pause_at);
        logic [CPU_W-1:0] hot_cpu;
        logic [CPU_W-1:0] cpu;
        logic [SUM_W-1:0] sum;
        hot_cpu = CPU_W'($urandom_range(7));
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) drain_results();
            if ($urandom_range(99) < 3) begin
                send_item(OP_TOUCH, CPU_W'($urandom), $urandom, 1'($urandom));
            end else begin
                if ($urandom_range(99) < 8) hot_cpu = CPU_W'($urandom_range(7));
                cpu = ($urandom_range(99) < 60) ? hot_cpu : CPU_W'($urandom_range(7));
                sum = ($urandom_range(99) < 88) ? sent_sum[cpu] : $urandom;
                send_item(OP_TICK, cpu, sum, $urandom_range(99) < 20);
            end
            if (i == hold_at) hold_requests++;
        end
        drain_results();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = OP_TICK;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = REG_TICKS_PER_SECOND;
        cfg_wdata = '0;
        no_idle   = 1'b0;
        hold_requests = 0;
        for (int i = 0; i < DEFAULT_NUM_CPUS; i++) sent_sum[i] = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: threshold five, no panic
        // stored counts start at zero, so a zero count already stalls
        repeat (6) send_item(OP_TICK, 3'd0, 32'd0, 1'b0);
        send_item(OP_TOUCH, 3'd7, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_TICK, 3'd0, 32'd0, 1'b0);
        // veto below the threshold is ignored, at the threshold it clears
        send_item(OP_TICK, 3'd7, 32'hFFFF_FFFF, 1'b1);
        repeat (5) send_item(OP_TICK, 3'd7, 32'hFFFF_FFFF, 1'b1);
        repeat (5) send_item(OP_TICK, 3'd7, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_TICK, 3'd3, 32'h8000_0001, 1'b0);
        send_item(OP_TICK, 3'd4, 32'h7FFF_FFFE, 1'b1);
        drain_results();

        set_watchdog(10'd1, 1'b1);
        random_ticks(110, 30, 70);
        set_watchdog(10'd2, 1'b0);
        random_ticks(100, -1, -1);
        // zero rate: threshold zero is never reached
        set_watchdog(10'd0, 1'b1);
        random_ticks(60, -1, -1);
        set_watchdog(10'd3, 1'b1);
        random_ticks(110, 50, -1);
        set_watchdog(10'd1023, 1'b0);
        random_ticks(40, -1, -1);

        // one long stall with no idling: lockup at fifty, then the counter runs on quietly
        set_watchdog(10'd10, 1'b1);
        no_idle = 1'b1;
        send_item(OP_TICK, 3'd5, 32'h1234_5678, 1'b0);
        for (int i = 1; i <= 60; i++)
            send_item(OP_TICK, 3'd5, 32'h1234_5678, (i == 50) ? 1'b0 : 1'($urandom));
        send_item(OP_TOUCH, 3'd5, 32'd0, 1'b0);
        send_item(OP_TICK, 3'd5, 32'h1234_5678, 1'b0);
        drain_results();
        no_idle = 1'b0;

        set_watchdog(10'd1, 1'b0);
        random_ticks(60, 20, -1);

        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
